// ----- rtl/sdspi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD card SPI-mode transaction engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned WriteBlockBytes = 512;
  localparam int unsigned ResponsePolls   = 11;
  localparam logic [23:0] OneSecReset     = 24'd31250;

  typedef enum logic [1:0] {
    CMD_START_CMD   = 2'd0,
    CMD_START_READ  = 2'd1,
    CMD_START_WRITE = 2'd2,
    CMD_SPI_BYTE    = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    KIND_REQUEST  = 2'd0,
    KIND_RESPONSE = 2'd1,
    KIND_DATA     = 2'd2,
    KIND_DONE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_READY_TMO  = 2'd1,
    ST_TOKEN_TMO  = 2'd2,
    ST_WR_REJECT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TXN_CMD   = 2'd0,
    TXN_READ  = 2'd1,
    TXN_WRITE = 2'd2
  } txn_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RDY_DUMMY, PH_RDY_POLL, PH_CMD_BYTE, PH_RESP_POLL,
    PH_RESP_COLLECT, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_TOKEN,
    PH_WR_DATA, PH_WR_CRC, PH_WR_RESP
  } phase_e;

  // One result beat: kind, tx_byte, wants_data, chip_select, value, status, last
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       wants_data;
    logic       chip_select;
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } result_t;

  // Registered input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  cmd_byte;
    logic [31:0] argument;
    logic [2:0]  response_length;
    logic [9:0]  block_length;
    logic [7:0]  data_token;
    logic [7:0]  rx_byte;
  } item_t;

endpackage

// ----- rtl/sd_spi_transaction_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_transaction_engine_top
// SD card SPI-mode host transaction engine, one exchanged byte per beat.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// s_axis    in         s_axis_tvalid/tready     command, fields, rx_byte
// m_axis    out        m_axis_tvalid/tready     result beat
// cfg       in         cfg_we_i                 one_second_bytes
//
// An input beat is registered, stepped and yields up to two result beats
// into the output register. A new input is taken every cycle the output
// register drains; an item with two results holds input while the second
// beat leaves. Reset is asynchronous; no clearing pass. Downstream stalls
// back-pressure the input side.
// ----------------------------------------------------------------------------
module sd_spi_transaction_engine_top #(
  parameter int unsigned WriteBlockBytes = sdspi_pkg::WriteBlockBytes,
  parameter int unsigned ResponsePolls   = sdspi_pkg::ResponsePolls
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] cmd_byte, [39:8] argument, [42:40] response_length,
  // [52:43] block_length, [60:53] data_token, [68:61] write_byte,
  // [76:69] rx_byte, [79:77] zero
  input  logic [79:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte, [8] wants_data, [9] chip_select, [17:10] value,
  // [19:18] status, [23:20] zero
  output logic [23:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i
);

  logic [23:0] one_sec_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) one_sec_q <= sdspi_pkg::OneSecReset;
    else if (cfg_we_i) one_sec_q <= cfg_wdata_i;
  end

  // Input register
  sdspi_pkg::item_t item_q;
  logic             item_v_q;
  logic             step, room;
  sdspi_pkg::result_t res [3];
  logic [1:0]       res_cnt;

  assign step          = item_v_q && room;
  assign s_axis_tready = !item_v_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) item_v_q <= 1'b0;
    else if (s_axis_tready) item_v_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.command         <= s_axis_tuser;
      item_q.cmd_byte        <= s_axis_tdata[7:0];
      item_q.argument        <= s_axis_tdata[39:8];
      item_q.response_length <= s_axis_tdata[42:40];
      item_q.block_length    <= s_axis_tdata[52:43];
      item_q.data_token      <= s_axis_tdata[60:53];
      item_q.rx_byte         <= s_axis_tdata[76:69];
    end
  end

  sdspi_core #(
    .WriteBlockBytes(WriteBlockBytes),
    .ResponsePolls  (ResponsePolls)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .one_sec_i(one_sec_q),
    .res_o    (res),
    .res_cnt_o(res_cnt)
  );

  sdspi_pkg::result_t beat;
  sdspi_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .cnt_i       (res_cnt),
    .empty_next_o(room),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .beat_o      (beat)
  );

  assign m_axis_tdata = {4'd0, beat.status, beat.value, beat.chip_select,
                         beat.wants_data, beat.tx_byte};
  assign m_axis_tuser = beat.kind;
  assign m_axis_tlast = beat.last;

endmodule

// ----- rtl/sdspi_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_core
// Transaction state and single-pass step logic: one input item in, up to
// two result beats out.
// ----------------------------------------------------------------------------
module sdspi_core #(
  parameter int unsigned WriteBlockBytes = sdspi_pkg::WriteBlockBytes,
  parameter int unsigned ResponsePolls   = sdspi_pkg::ResponsePolls
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sdspi_pkg::item_t   item_i,
  input  logic [23:0]        one_sec_i,
  output sdspi_pkg::result_t res_o [3],
  output logic [1:0]         res_cnt_o
);

  localparam int unsigned WbW = $clog2(WriteBlockBytes + 1);
  localparam int unsigned CntW = (WbW > 10) ? WbW : 10;

  sdspi_pkg::phase_e phase_q, phase_d;
  sdspi_pkg::txn_e   txn_q, txn_d;
  logic [23:0]   retry_q, retry_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]    scmd_q, scmd_d;
  logic [31:0]   sarg_q, sarg_d;
  logic [9:0]    slen_q, slen_d;
  logic          app_q, app_d;
  logic          sel_q, sel_d;
  logic [7:0]    first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdspi_pkg::PH_IDLE;
      txn_q   <= sdspi_pkg::TXN_CMD;
      retry_q <= '0;
      cnt_q   <= '0;
      scmd_q  <= '0;
      sarg_q  <= '0;
      slen_q  <= '0;
      app_q   <= 1'b0;
      sel_q   <= 1'b1;
      first_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      txn_q   <= txn_d;
      retry_q <= retry_d;
      cnt_q   <= cnt_d;
      scmd_q  <= scmd_d;
      sarg_q  <= sarg_d;
      slen_q  <= slen_d;
      app_q   <= app_d;
      sel_q   <= sel_d;
      first_q <= first_d;
    end
  end

  logic [23:0] bud_rdy, bud_tok;
  assign bud_rdy = ((one_sec_i >> 1) == 24'd0) ? 24'd1 : (one_sec_i >> 1);
  assign bud_tok = ((one_sec_i >> 3) == 24'd0) ? 24'd1 : (one_sec_i >> 3);

  logic [7:0] cur_cmd, cmdb, rx;
  logic [31:0] cur_arg;
  logic [CntW-1:0] cnt_inc;
  assign cur_cmd = app_q ? 8'h77 : scmd_q;
  assign cur_arg = app_q ? 32'd0 : sarg_q;
  assign rx      = item_i.rx_byte;
  assign cnt_inc = cnt_q + CntW'(1);

  // Command byte at index cnt_inc (1..5)
  always_comb begin
    case (cnt_inc[2:0])
      3'd1:    cmdb = cur_arg[31:24];
      3'd2:    cmdb = cur_arg[23:16];
      3'd3:    cmdb = cur_arg[15:8];
      3'd4:    cmdb = cur_arg[7:0];
      default: cmdb = (cur_cmd == 8'h40) ? 8'h95 : (cur_cmd == 8'h48) ? 8'h87 : 8'h01;
    endcase
  end

  logic [1:0] n;
  sdspi_pkg::result_t r [3];

  // Build a beat; select level uses the value current at append time
  function automatic sdspi_pkg::result_t mk(logic [1:0] k, logic [7:0] tx, logic w,
                                            logic cs, logic [7:0] v, logic [1:0] s);
    sdspi_pkg::result_t t;
    t.kind = k; t.tx_byte = tx; t.wants_data = w; t.chip_select = cs;
    t.value = v; t.status = s; t.last = 1'b0;
    return t;
  endfunction

  always_comb begin
    phase_d = phase_q; txn_d = txn_q; retry_d = retry_q; cnt_d = cnt_q;
    scmd_d = scmd_q; sarg_d = sarg_q; slen_d = slen_q; app_d = app_q;
    sel_d = sel_q; first_d = first_q;
    n = 2'd0;
    for (int i = 0; i < 3; i++) r[i] = '0;

    if (item_i.command == sdspi_pkg::CMD_SPI_BYTE) begin
      case (phase_q)
        sdspi_pkg::PH_IDLE: ;
        sdspi_pkg::PH_RDY_DUMMY: begin
          retry_d = bud_rdy; phase_d = sdspi_pkg::PH_RDY_POLL;
          r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0); n = 2'd1;
        end
        sdspi_pkg::PH_RDY_POLL: begin
          n = 2'd1;
          if (rx == 8'hFF) begin
            if (txn_q == sdspi_pkg::TXN_CMD) begin
              phase_d = sdspi_pkg::PH_CMD_BYTE; cnt_d = '0;
              r[0] = mk(sdspi_pkg::KIND_REQUEST, cur_cmd, 1'b0, sel_q, 8'd0, 2'd0);
            end else begin
              phase_d = sdspi_pkg::PH_WR_TOKEN;
              r[0] = mk(sdspi_pkg::KIND_REQUEST, scmd_q, 1'b0, sel_q, 8'd0, 2'd0);
            end
          end else if (retry_q <= 24'd1) begin
            phase_d = sdspi_pkg::PH_IDLE; app_d = 1'b0;
            if (txn_q == sdspi_pkg::TXN_CMD) begin
              first_d = 8'hFF;
              r[0] = mk(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, sel_q, 8'hFF,
                        sdspi_pkg::ST_READY_TMO);
            end else begin
              r[0] = mk(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, sel_q, 8'd0,
                        sdspi_pkg::ST_READY_TMO);
            end
          end else begin
            retry_d = retry_q - 24'd1;
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
          end
        end
        sdspi_pkg::PH_CMD_BYTE: begin
          cnt_d = cnt_inc; n = 2'd1;
          if (cnt_inc < CntW'(6)) begin
            r[0] = mk(sdspi_pkg::KIND_REQUEST, cmdb, 1'b0, sel_q, 8'd0, 2'd0);
          end else if (cnt_inc == CntW'(6) && cur_cmd == 8'h4C) begin
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
          end else if (slen_q != 10'd0) begin
            phase_d = sdspi_pkg::PH_RESP_POLL; cnt_d = '0;
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
          end else if (app_q && first_q <= 8'd1) begin
            // prefix done with no response: start the real command
            app_d = 1'b0; sel_d = 1'b0; phase_d = sdspi_pkg::PH_RDY_DUMMY;
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, 1'b0, 8'd0, 2'd0);
          end else begin
            phase_d = sdspi_pkg::PH_IDLE; app_d = 1'b0;
            r[0] = mk(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, sel_q, first_q, sdspi_pkg::ST_OK);
          end
        end
        sdspi_pkg::PH_RESP_POLL, sdspi_pkg::PH_RESP_COLLECT: begin
          logic [7:0] fr;
          logic       fin;
          fr  = first_q;
          fin = 1'b0;
          n = 2'd2;
          if (phase_q == sdspi_pkg::PH_RESP_POLL) begin
            if (rx != 8'hFF) begin
              fr = rx; first_d = rx;
              r[0] = mk(sdspi_pkg::KIND_RESPONSE, 8'd0, 1'b0, sel_q, rx, 2'd0);
              if (slen_q > 10'd1) begin
                phase_d = sdspi_pkg::PH_RESP_COLLECT; cnt_d = CntW'(1);
                r[1] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
              end else fin = 1'b1;
            end else begin
              cnt_d = cnt_inc;
              if (cnt_inc >= CntW'(ResponsePolls)) begin
                fr = 8'hFF; first_d = 8'hFF; fin = 1'b1;
                r[0] = mk(sdspi_pkg::KIND_RESPONSE, 8'd0, 1'b0, sel_q, 8'hFF, 2'd0);
              end else begin
                n = 2'd1;
                r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
              end
            end
          end else begin
            r[0] = mk(sdspi_pkg::KIND_RESPONSE, 8'd0, 1'b0, sel_q, rx, 2'd0);
            cnt_d = cnt_inc;
            if (cnt_inc >= CntW'(slen_q)) fin = 1'b1;
            else r[1] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
          end
          if (fin) begin
            if (app_q && fr <= 8'd1) begin
              app_d = 1'b0; sel_d = 1'b0; phase_d = sdspi_pkg::PH_RDY_DUMMY;
              r[1] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, 1'b0, 8'd0, 2'd0);
            end else begin
              phase_d = sdspi_pkg::PH_IDLE; app_d = 1'b0;
              r[1] = mk(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, sel_q, fr, sdspi_pkg::ST_OK);
            end
          end
        end
        sdspi_pkg::PH_RD_TOKEN: begin
          n = 2'd1;
          if (rx == 8'hFE) begin
            cnt_d = '0;
            phase_d = (slen_q != 10'd0) ? sdspi_pkg::PH_RD_DATA : sdspi_pkg::PH_RD_CRC;
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
          end else if (retry_q <= 24'd1) begin
            phase_d = sdspi_pkg::PH_IDLE; app_d = 1'b0;
            r[0] = mk(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, sel_q, 8'd0,
                      sdspi_pkg::ST_TOKEN_TMO);
          end else begin
            retry_d = retry_q - 24'd1;
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
          end
        end
        sdspi_pkg::PH_RD_DATA: begin
          n = 2'd2;
          r[0] = mk(sdspi_pkg::KIND_DATA, 8'd0, 1'b0, sel_q, rx, 2'd0);
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(slen_q)) begin
            phase_d = sdspi_pkg::PH_RD_CRC; cnt_d = '0;
          end
          r[1] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
        end
        sdspi_pkg::PH_RD_CRC: begin
          n = 2'd1; cnt_d = cnt_inc;
          if (cnt_inc < CntW'(2)) begin
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
          end else begin
            phase_d = sdspi_pkg::PH_IDLE; app_d = 1'b0;
            r[0] = mk(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, sel_q, 8'd0, sdspi_pkg::ST_OK);
          end
        end
        sdspi_pkg::PH_WR_TOKEN: begin
          n = 2'd1;
          if (scmd_q == 8'hFD) begin
            phase_d = sdspi_pkg::PH_IDLE; app_d = 1'b0;
            r[0] = mk(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, sel_q, 8'd0, sdspi_pkg::ST_OK);
          end else begin
            phase_d = sdspi_pkg::PH_WR_DATA; cnt_d = '0;
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'd0, 1'b1, sel_q, 8'd0, 2'd0);
          end
        end
        sdspi_pkg::PH_WR_DATA: begin
          n = 2'd1; cnt_d = cnt_inc;
          if (cnt_inc < CntW'(WriteBlockBytes)) begin
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'd0, 1'b1, sel_q, 8'd0, 2'd0);
          end else begin
            phase_d = sdspi_pkg::PH_WR_CRC; cnt_d = '0;
            r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
          end
        end
        sdspi_pkg::PH_WR_CRC: begin
          n = 2'd1; cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(2)) phase_d = sdspi_pkg::PH_WR_RESP;
          r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
        end
        sdspi_pkg::PH_WR_RESP: begin
          n = 2'd1; phase_d = sdspi_pkg::PH_IDLE; app_d = 1'b0;
          r[0] = mk(sdspi_pkg::KIND_DONE, 8'd0, 1'b0, sel_q, rx,
                    (rx[4:0] == 5'h05) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_WR_REJECT);
        end
        default: ;
      endcase
    end else if (phase_q == sdspi_pkg::PH_IDLE) begin
      n = 2'd1;
      case (item_i.command)
        sdspi_pkg::CMD_START_CMD: begin
          txn_d = sdspi_pkg::TXN_CMD;
          app_d = item_i.cmd_byte[7];
          scmd_d = {1'b0, item_i.cmd_byte[6:0]};
          sarg_d = item_i.argument;
          slen_d = {7'd0, item_i.response_length};
          first_d = '0; sel_d = 1'b0; phase_d = sdspi_pkg::PH_RDY_DUMMY;
          r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, 1'b0, 8'd0, 2'd0);
        end
        sdspi_pkg::CMD_START_READ: begin
          txn_d = sdspi_pkg::TXN_READ;
          slen_d = item_i.block_length;
          retry_d = bud_tok; phase_d = sdspi_pkg::PH_RD_TOKEN;
          r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
        end
        default: begin
          txn_d = sdspi_pkg::TXN_WRITE;
          scmd_d = item_i.data_token; phase_d = sdspi_pkg::PH_RDY_DUMMY;
          r[0] = mk(sdspi_pkg::KIND_REQUEST, 8'hFF, 1'b0, sel_q, 8'd0, 2'd0);
        end
      endcase
    end

    if (n == 2'd1) r[0].last = 1'b1;
    else if (n == 2'd2) r[1].last = 1'b1;
  end

  assign res_o     = r;
  assign res_cnt_o = n;

endmodule

// ----- rtl/sdspi_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_out_buf
// Result register: holds the beats of one item and drains them in order.
// ----------------------------------------------------------------------------
module sdspi_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sdspi_pkg::result_t res_i [3],
  input  logic [1:0]         cnt_i,
  output logic               empty_next_o,
  output logic               valid_o,
  input  logic               ready_i,
  output sdspi_pkg::result_t beat_o
);

  sdspi_pkg::result_t buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       pos_q, pos_d;

  // Buffer can take a new set when empty or once the last held beat leaves this cycle
  assign empty_next_o = (cnt_q == 2'd0) ||
                        (ready_i && (cnt_q == {1'b0, pos_q} + 2'd1));

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (valid_o && ready_i) begin
      if (cnt_q == {1'b0, pos_q} + 2'd1) begin
        cnt_d = 2'd0; pos_d = 1'b0;
      end else pos_d = 1'b1;
    end
    if (load_i) begin
      cnt_d = cnt_i; pos_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      pos_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q[0] <= res_i[0];
      buf_q[1] <= res_i[1];
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign beat_o  = buf_q[pos_q];

endmodule

// ----- dv/sd_spi_transaction_engine_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_transaction_engine_top_test
// Self-checking bench for the SD SPI-mode transaction engine. A simple card
// model answers every exchange request; an internal copy of the engine
// predicts every result beat, which is compared field by field as it leaves.
// ----------------------------------------------------------------------------
module sd_spi_transaction_engine_top_test;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;

  sd_spi_transaction_engine_top dut (.*);

  always #6 clk_i = ~clk_i;

  typedef struct {
    sdspi_pkg::kind_e   kind;
    logic [7:0]         tx;
    logic               wants;
    logic               cs;
    logic [7:0]         value;
    sdspi_pkg::status_e st;
    logic               last;
  } beat_t;

  beat_t expected_beats[$];
  int    errors = 0;
  int    items_sent = 0;
  int    beats_added;
  bit    gaps_on = 1'b1;

  // card behaviour knobs, percentages; resp_fix forces the response byte when >= 0
  int ready_pct = 100;
  int resp_pct = 100;
  int resp_fix = -1;
  int token_pct = 100;
  int wr_ok_pct = 100;

  // engine copy
  logic [23:0]       rate;
  sdspi_pkg::phase_e ph;
  logic [23:0]       retry;
  logic [9:0]        bcnt;
  logic [7:0]        s_cmd;
  logic [31:0]       s_arg;
  logic [9:0]        s_len;
  logic              app;
  logic              sel;
  sdspi_pkg::txn_e   txn;
  logic [7:0]        first_resp;

  function automatic void add(sdspi_pkg::kind_e k, logic [7:0] tx, logic w, logic [7:0] v,
                              sdspi_pkg::status_e s);
    expected_beats.push_back('{k, tx, w, sel, v, s, 1'b0});
    beats_added++;
  endfunction

  function automatic void req(logic [7:0] tx);
    add(sdspi_pkg::KIND_REQUEST, tx, 1'b0, 8'h00, sdspi_pkg::ST_OK);
  endfunction

  function automatic void done(sdspi_pkg::status_e s, logic [7:0] v);
    ph = sdspi_pkg::PH_IDLE;
    app = 1'b0;
    add(sdspi_pkg::KIND_DONE, 8'h00, 1'b0, v, s);
  endfunction

  function automatic logic [23:0] budget(int sh);
    logic [23:0] r;
    r = rate >> sh;
    return (r != 0) ? r : 24'd1;
  endfunction

  function automatic logic [7:0] cur_cmd();
    return app ? 8'h77 : s_cmd;
  endfunction

  function automatic logic [7:0] cmd_at(int i);
    logic [31:0] a;
    a = app ? 32'h0 : s_arg;
    if (i == 0) return cur_cmd();
    if (i <= 4) return a[8*(4-i) +: 8];
    if (cur_cmd() == 8'h40) return 8'h95;
    if (cur_cmd() == 8'h48) return 8'h87;
    return 8'h01;
  endfunction

  function automatic void begin_cmd();
    sel = 1'b0;
    ph = sdspi_pkg::PH_RDY_DUMMY;
    req(8'hFF);
  endfunction

  function automatic void finish_cmd();
    if (app) begin
      app = 1'b0;
      if (first_resp > 1) done(sdspi_pkg::ST_OK, first_resp);
      else begin_cmd();
    end else begin
      done(sdspi_pkg::ST_OK, first_resp);
    end
  endfunction

  function automatic void advance(logic [7:0] rx);
    case (ph)
      sdspi_pkg::PH_RDY_DUMMY: begin
        retry = budget(1);
        ph = sdspi_pkg::PH_RDY_POLL;
        req(8'hFF);
      end
      sdspi_pkg::PH_RDY_POLL: begin
        if (rx == 8'hFF) begin
          if (txn == sdspi_pkg::TXN_CMD) begin
            ph = sdspi_pkg::PH_CMD_BYTE;
            bcnt = 0;
            req(cmd_at(0));
          end else begin
            ph = sdspi_pkg::PH_WR_TOKEN;
            req(s_cmd);
          end
        end else if (retry <= 1) begin
          if (txn == sdspi_pkg::TXN_CMD) begin
            first_resp = 8'hFF;
            done(sdspi_pkg::ST_READY_TMO, 8'hFF);
          end else begin
            done(sdspi_pkg::ST_READY_TMO, 8'h00);
          end
        end else begin
          retry--;
          req(8'hFF);
        end
      end
      sdspi_pkg::PH_CMD_BYTE: begin
        bcnt++;
        if (bcnt < 6) req(cmd_at(bcnt));
        else if (bcnt == 6 && cur_cmd() == 8'h4C) req(8'hFF);
        else if (s_len == 0) finish_cmd();
        else begin
          ph = sdspi_pkg::PH_RESP_POLL;
          bcnt = 0;
          req(8'hFF);
        end
      end
      sdspi_pkg::PH_RESP_POLL: begin
        if (rx != 8'hFF) begin
          first_resp = rx;
          add(sdspi_pkg::KIND_RESPONSE, 8'h00, 1'b0, rx, sdspi_pkg::ST_OK);
          if (s_len > 1) begin
            ph = sdspi_pkg::PH_RESP_COLLECT;
            bcnt = 1;
            req(8'hFF);
          end else begin
            finish_cmd();
          end
        end else begin
          bcnt++;
          if (bcnt >= sdspi_pkg::ResponsePolls) begin
            first_resp = 8'hFF;
            add(sdspi_pkg::KIND_RESPONSE, 8'h00, 1'b0, 8'hFF, sdspi_pkg::ST_OK);
            finish_cmd();
          end else begin
            req(8'hFF);
          end
        end
      end
      sdspi_pkg::PH_RESP_COLLECT: begin
        add(sdspi_pkg::KIND_RESPONSE, 8'h00, 1'b0, rx, sdspi_pkg::ST_OK);
        bcnt++;
        if (bcnt >= s_len) finish_cmd();
        else req(8'hFF);
      end
      sdspi_pkg::PH_RD_TOKEN: begin
        if (rx == 8'hFE) begin
          bcnt = 0;
          ph = (s_len != 0) ? sdspi_pkg::PH_RD_DATA : sdspi_pkg::PH_RD_CRC;
          req(8'hFF);
        end else if (retry <= 1) begin
          done(sdspi_pkg::ST_TOKEN_TMO, 8'h00);
        end else begin
          retry--;
          req(8'hFF);
        end
      end
      sdspi_pkg::PH_RD_DATA: begin
        add(sdspi_pkg::KIND_DATA, 8'h00, 1'b0, rx, sdspi_pkg::ST_OK);
        bcnt++;
        if (bcnt >= s_len) begin
          ph = sdspi_pkg::PH_RD_CRC;
          bcnt = 0;
        end
        req(8'hFF);
      end
      sdspi_pkg::PH_RD_CRC: begin
        bcnt++;
        if (bcnt < 2) req(8'hFF);
        else done(sdspi_pkg::ST_OK, 8'h00);
      end
      sdspi_pkg::PH_WR_TOKEN: begin
        if (s_cmd == 8'hFD) begin
          done(sdspi_pkg::ST_OK, 8'h00);
        end else begin
          ph = sdspi_pkg::PH_WR_DATA;
          bcnt = 0;
          add(sdspi_pkg::KIND_REQUEST, 8'h00, 1'b1, 8'h00, sdspi_pkg::ST_OK);
        end
      end
      sdspi_pkg::PH_WR_DATA: begin
        bcnt++;
        if (bcnt < sdspi_pkg::WriteBlockBytes) begin
          add(sdspi_pkg::KIND_REQUEST, 8'h00, 1'b1, 8'h00, sdspi_pkg::ST_OK);
        end else begin
          ph = sdspi_pkg::PH_WR_CRC;
          bcnt = 0;
          req(8'hFF);
        end
      end
      sdspi_pkg::PH_WR_CRC: begin
        bcnt++;
        if (bcnt >= 2) ph = sdspi_pkg::PH_WR_RESP;
        req(8'hFF);
      end
      sdspi_pkg::PH_WR_RESP:
        done((rx[4:0] == 5'h05) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_WR_REJECT, rx);
      default: ;
    endcase
  endfunction

  function automatic void engine_step(sdspi_pkg::command_e c, logic [7:0] cb,
                                      logic [31:0] arg, logic [2:0] rl, logic [9:0] bl,
                                      logic [7:0] tok, logic [7:0] rx);
    beats_added = 0;
    if (c == sdspi_pkg::CMD_SPI_BYTE) begin
      if (ph != sdspi_pkg::PH_IDLE) advance(rx);
    end else if (ph == sdspi_pkg::PH_IDLE) begin
      case (c)
        sdspi_pkg::CMD_START_CMD: begin
          txn = sdspi_pkg::TXN_CMD;
          app = cb[7];
          s_cmd = {1'b0, cb[6:0]};
          s_arg = arg;
          s_len = {7'd0, rl};
          first_resp = 8'h00;
          begin_cmd();
        end
        sdspi_pkg::CMD_START_READ: begin
          txn = sdspi_pkg::TXN_READ;
          s_len = bl;
          retry = budget(3);
          ph = sdspi_pkg::PH_RD_TOKEN;
          req(8'hFF);
        end
        default: begin
          txn = sdspi_pkg::TXN_WRITE;
          s_cmd = tok;
          ph = sdspi_pkg::PH_RDY_DUMMY;
          req(8'hFF);
        end
      endcase
    end
    if (beats_added > 0) expected_beats[expected_beats.size()-1].last = 1'b1;
  endfunction

  // card answer for the exchange the engine is waiting on
  function automatic logic [7:0] card_byte();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (ph)
      sdspi_pkg::PH_RDY_POLL:
        r = ($urandom_range(0, 99) < ready_pct) ? 8'hFF : 8'($urandom_range(0, 254));
      sdspi_pkg::PH_RESP_POLL: begin
        if ($urandom_range(0, 99) >= resp_pct) r = 8'hFF;
        else if (resp_fix >= 0) r = 8'(resp_fix);
        else if ($urandom_range(0, 2) != 0) r = 8'($urandom_range(0, 1));
        else r = 8'($urandom_range(0, 254));
      end
      sdspi_pkg::PH_RD_TOKEN:
        r = ($urandom_range(0, 99) < token_pct) ? 8'hFE : 8'($urandom_range(0, 253));
      sdspi_pkg::PH_WR_RESP: begin
        if ($urandom_range(0, 99) < wr_ok_pct) r[4:0] = 5'h05;
        else if (r[4:0] == 5'h05) r[0] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_beat(sdspi_pkg::command_e c, logic [7:0] cb, logic [31:0] arg,
                           logic [2:0] rl, logic [9:0] bl, logic [7:0] tok, logic [7:0] rx);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = c;
    s_axis_tdata = {3'b000, rx, 8'($urandom_range(0, 255)), tok, bl, rl, arg, cb};
    do @(posedge clk_i); while (!s_axis_tready);
    engine_step(c, cb, arg, rl, bl, tok, rx);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic spi_beat(logic [7:0] rx);
    send_beat(sdspi_pkg::CMD_SPI_BYTE, 8'($urandom), $urandom, 3'($urandom), 10'($urandom),
              8'($urandom), rx);
  endtask

  // start a transaction and answer as the card until it completes
  task automatic run_txn(sdspi_pkg::command_e c, logic [7:0] cb, logic [31:0] arg,
                         logic [2:0] rl, logic [9:0] bl, logic [7:0] tok);
    send_beat(c, cb, arg, rl, bl, tok, 8'($urandom));
    while (ph != sdspi_pkg::PH_IDLE) begin
      // start while busy: dropped
      if ($urandom_range(0, 39) == 0)
        send_beat(sdspi_pkg::command_e'($urandom_range(0, 2)), 8'($urandom), $urandom,
                  3'($urandom), 10'($urandom), 8'($urandom), 8'($urandom));
      spi_beat(card_byte());
    end
  endtask

  task automatic drain();
    int n;
    s_axis_tvalid = 1'b0;
    for (n = 0; n < 200000 && expected_beats.size() != 0; n++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_rate(logic [23:0] v);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    rate = v;
  endtask

  task automatic card_nominal();
    ready_pct = 100;
    resp_pct = 100;
    resp_fix = -1;
    token_pct = 100;
    wr_ok_pct = 100;
  endtask

  task automatic test_commands();
    card_nominal();
    spi_beat(8'h00);  // byte while idle: dropped
    resp_fix = 1;
    run_txn(sdspi_pkg::CMD_START_CMD, 8'h40, 32'h0000_0000, 3'd1, 10'd0, 8'h00);
    run_txn(sdspi_pkg::CMD_START_CMD, 8'h48, 32'hFFFF_FFFF, 3'd5, 10'd0, 8'h00);
    run_txn(sdspi_pkg::CMD_START_CMD, 8'h4C, 32'h1234_5678, 3'd7, 10'd0, 8'h00);
    resp_fix = 0;
    run_txn(sdspi_pkg::CMD_START_CMD, 8'hE9, 32'h4000_0000, 3'd1, 10'd0, 8'h00);
    resp_fix = 8'h05;  // app prefix rejected
    run_txn(sdspi_pkg::CMD_START_CMD, 8'hE9, 32'hA5A5_5A5A, 3'd2, 10'd0, 8'h00);
    run_txn(sdspi_pkg::CMD_START_CMD, 8'hFF, 32'h0000_00FF, 3'd0, 10'd0, 8'h00);
    resp_pct = 0;      // card silent
    run_txn(sdspi_pkg::CMD_START_CMD, 8'h51, 32'h8000_0001, 3'd1, 10'd0, 8'h00);
    run_txn(sdspi_pkg::CMD_START_CMD, 8'hC1, 32'h0000_0000, 3'd3, 10'd0, 8'h00);
  endtask

  task automatic test_reads();
    card_nominal();
    run_txn(sdspi_pkg::CMD_START_READ, 8'h00, 32'h0, 3'd0, 10'd0, 8'h00);
    run_txn(sdspi_pkg::CMD_START_READ, 8'h00, 32'h0, 3'd0, 10'd1, 8'h00);
    run_txn(sdspi_pkg::CMD_START_READ, 8'h00, 32'h0, 3'd0, 10'd6, 8'h00);
    run_txn(sdspi_pkg::CMD_START_READ, 8'h00, 32'h0, 3'd0, 10'd33, 8'h00);
    // token budget shifts down to zero and still allows one poll
    set_rate(24'd4);
    token_pct = 0;
    run_txn(sdspi_pkg::CMD_START_READ, 8'h00, 32'h0, 3'd0, 10'd4, 8'h00);
  endtask

  task automatic test_writes();
    card_nominal();
    wr_ok_pct = 50;
    run_txn(sdspi_pkg::CMD_START_WRITE, 8'h00, 32'h0, 3'd0, 10'd0, 8'hFE);
    run_txn(sdspi_pkg::CMD_START_WRITE, 8'h00, 32'h0, 3'd0, 10'd0, 8'hFD);
    ready_pct = 0;
    run_txn(sdspi_pkg::CMD_START_WRITE, 8'h00, 32'h0, 3'd0, 10'd0, 8'hFE);
    run_txn(sdspi_pkg::CMD_START_CMD, 8'h58, 32'h0000_0010, 3'd1, 10'd0, 8'h00);
  endtask

  task automatic test_random(int stop_at, bit allow_zero);
    int lo;
    logic [7:0] cb;
    lo = allow_zero ? 0 : 20;
    while (items_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      ready_pct = $urandom_range(lo, 100);
      resp_pct = $urandom_range(lo, 100);
      resp_fix = -1;
      token_pct = $urandom_range(lo, 100);
      wr_ok_pct = $urandom_range(0, 100);
      if ($urandom_range(0, 9) == 0) spi_beat(8'($urandom));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          case ($urandom_range(0, 4))
            0: cb = 8'h40;
            1: cb = 8'h48;
            2: cb = 8'h4C;
            3: cb = 8'h69;
            default: cb = 8'($urandom);
          endcase
          cb[7] = $urandom_range(0, 1);
          run_txn(sdspi_pkg::CMD_START_CMD, cb, $urandom, 3'($urandom), 10'($urandom),
                  8'($urandom));
        end
        5, 6, 7:
          run_txn(sdspi_pkg::CMD_START_READ, 8'($urandom), $urandom, 3'($urandom),
                  ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 40))
                                              : 10'($urandom_range(0, 6)),
                  8'($urandom));
        default:
          run_txn(sdspi_pkg::CMD_START_WRITE, 8'($urandom), $urandom, 3'($urandom),
                  10'($urandom), 8'hFD);
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // result side: random stalls, compare each beat
  int stall = 0;
  always @(negedge clk_i) begin
    if (stall > 0) begin
      m_axis_tready = 1'b0;
      stall--;
    end else begin
      m_axis_tready = 1'b1;
      if (gaps_on && $urandom_range(0, 3) == 0) stall = $urandom_range(0, 16);
    end
  end

  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat kind=%0d data=%h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (m_axis_tuser != e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[7:0] != e.tx) begin
          $error("tx_byte: expected %h, got %h", e.tx, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[8] != e.wants) begin
          $error("wants_data: expected %0d, got %0d", e.wants, m_axis_tdata[8]);
          errors++;
        end
        if (m_axis_tdata[9] != e.cs) begin
          $error("chip_select: expected %0d, got %0d", e.cs, m_axis_tdata[9]);
          errors++;
        end
        if (m_axis_tdata[17:10] != e.value) begin
          $error("value: expected %h, got %h", e.value, m_axis_tdata[17:10]);
          errors++;
        end
        if (m_axis_tdata[19:18] != e.st) begin
          $error("status: expected %0d, got %0d", e.st, m_axis_tdata[19:18]);
          errors++;
        end
        if (m_axis_tlast != e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rate = sdspi_pkg::OneSecReset;
    ph = sdspi_pkg::PH_IDLE;
    retry = '0;
    bcnt = '0;
    s_cmd = '0;
    s_arg = '0;
    s_len = '0;
    app = 1'b0;
    sel = 1'b1;
    txn = sdspi_pkg::TXN_CMD;
    first_resp = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_commands();
    test_reads();
    test_writes();
    set_rate(24'd16777215);
    test_random(items_sent + 30, 1'b0);
    set_rate(24'd9);
    test_random(items_sent + 50, 1'b1);
    set_rate(24'd40);
    test_random(items_sent + 40, 1'b1);
    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
